// File: design/mcr_pkg.sv
package mcr_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int IN_BITS        = 11;
    localparam int OUT_BITS       = 12;
    localparam int CFG_BITS       = 11;
    localparam int CFG_ADDR_BITS  = 1;
    localparam int DEC_BITS       = 16;
    localparam int LANES          = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd240;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd320;

    localparam logic [DEC_BITS-1:0] DEC_INIT     = 16'd3;
    localparam logic [DEC_BITS-1:0] DEC_STEP_INC = 16'd6;
    localparam logic [DEC_BITS-1:0] DEC_DIAG_INC = 16'd10;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_SPAN  = 2'd2
    } t_kind;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } t_cfg_reg;

    // octant pixel i is dropped when any of its edge-clip bits is set
    localparam logic [LANES-1:0] SKIP_MASK [LANES] = '{
        8'h03, 8'h12, 8'h21, 8'h30, 8'h0C, 8'h48, 8'h84, 8'hC0
    };
    localparam logic [LANES-1:0] FILL_MASK = 8'h0F;

    typedef struct packed {
        logic [OUT_BITS-1:0] px;
        logic [OUT_BITS-1:0] py;
        logic [OUT_BITS-1:0] len;
    } t_entry;

    typedef struct packed {
        t_kind                 kind;
        logic                  finished;
        logic [LANES-1:0]      mask;
        t_entry [LANES-1:0]    entry;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: design/mcr_if.sv
interface mcr_in_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [mcr_pkg::IN_BITS-1:0]  center_x;
    logic [mcr_pkg::IN_BITS-1:0]  center_y;
    logic [mcr_pkg::IN_BITS-1:0]  radius;
    logic                         fill_mode;

    modport source (output valid, req_type, center_x, center_y, radius, fill_mode,
                    input ready);
    modport sink   (input valid, req_type, center_x, center_y, radius, fill_mode,
                    output ready);
endinterface

interface mcr_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [mcr_pkg::OUT_BITS-1:0]  pos_x;
    logic [mcr_pkg::OUT_BITS-1:0]  pos_y;
    logic [mcr_pkg::OUT_BITS-1:0]  span_length;
    logic                          last;
    logic                          finished;

    modport source (output valid, kind, pos_x, pos_y, span_length, last, finished,
                    input ready);
    modport sink   (input valid, kind, pos_x, pos_y, span_length, last, finished,
                    output ready);
endinterface

interface mcr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mcr_pkg::CFG_ADDR_BITS-1:0]  addr;
    logic [mcr_pkg::CFG_BITS-1:0]       data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// File: design/midpoint_circle_rasterizer.sv
// path: the first word of a step passes through the job queue and then the output register
// throughput: one word per cycle from the back end while the receiver is ready; an outline step
// gives up to 8 words, a fill step 4, a start none; the single output register sends them one by one
// the front takes a request every cycle while the 2-entry job queue has room
// reset: synchronous, active low; clears the circle state and queue, screen size to 240 x 320
module midpoint_circle_rasterizer #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mcr_in_if.sink     i_in,
    mcr_cfg_if.sink    i_cfg,
    mcr_out_if.source  o_out
);
    import mcr_pkg::*;

    logic     q_push, q_pop;
    t_job     front_job, head_job;
    t_q_stat  q_stat;

    mcr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    mcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    mcr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("job queue reports full and empty together");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("back end retired a job from an empty queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_stat.full && !q_pop) |=> !q_stat.empty)
        else $error("queue lost jobs while full");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_NONE) |-> o_out.last)
        else $error("empty word not marked last");

endmodule

// File: design/mcr_front.sv
module mcr_front #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mcr_in_if.sink            i_in,
    mcr_cfg_if.sink           i_cfg,
    input  mcr_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output mcr_pkg::t_job     o_job
);
    import mcr_pkg::*;

    // the input fields are only 11 bits wide, so wider settings change nothing
    localparam int CW = (COORD_BITS < IN_BITS) ? COORD_BITS : IN_BITS;
    localparam int SW = CW + 2;

    logic [CFG_BITS-1:0]        r_width, n_width;
    logic [CFG_BITS-1:0]        r_height, n_height;
    logic [CW-1:0]              r_cx, n_cx;
    logic [CW-1:0]              r_cy, n_cy;
    logic signed [SW-1:0]       r_x, n_x;
    logic signed [SW-1:0]       r_y, n_y;
    logic [DEC_BITS-1:0]        r_dec, n_dec;
    logic                       r_fill, n_fill;
    logic                       r_active, n_active;

    logic                       in_acc;
    logic                       is_step;
    logic                       idle;
    logic [CW-1:0]              x, y, rad;
    logic                       x_gt_cx, y_gt_cy, y_gt_cx, x_gt_cy;
    logic [CW-1:0]              l1, t2, l3, t4;
    logic [CW:0]                r5, b6, r7, b8;
    logic [CW:0]                len_a, len_b;
    logic [LANES-1:0]           skip;
    logic [OUT_BITS-1:0]        pix_x [LANES];
    logic [OUT_BITS-1:0]        pix_y [LANES];
    logic signed [SW-1:0]       x_next, y_next;
    logic [DEC_BITS-1:0]        x16, y16;
    logic                       dec_neg;

    assign in_acc      = i_in.valid && i_in.ready;
    assign is_step     = (t_req'(i_in.req_type) == REQ_STEP);
    assign i_in.ready  = !i_q_stat.full;
    assign i_cfg.ready = 1'b1;

    assign idle = !r_active || (r_x > r_y);
    assign x    = r_x[CW-1:0];
    assign y    = r_y[CW-1:0];
    assign rad  = i_in.radius[CW-1:0];

    assign x_gt_cx = x > r_cx;
    assign y_gt_cy = y > r_cy;
    assign y_gt_cx = y > r_cx;
    assign x_gt_cy = x > r_cy;

    // left and top edges clamp at zero
    assign l1 = x_gt_cx ? '0 : r_cx - x;
    assign t2 = y_gt_cy ? '0 : r_cy - y;
    assign l3 = y_gt_cx ? '0 : r_cx - y;
    assign t4 = x_gt_cy ? '0 : r_cy - x;
    assign r5 = {1'b0, r_cx} + {1'b0, x};
    assign b6 = {1'b0, r_cy} + {1'b0, y};
    assign r7 = {1'b0, r_cx} + {1'b0, y};
    assign b8 = {1'b0, r_cy} + {1'b0, x};

    // right minus clamped left: either the full right edge or twice the offset
    assign len_a = x_gt_cx ? r5 : {x, 1'b0};
    assign len_b = y_gt_cx ? r7 : {y, 1'b0};

    assign skip[0] = x_gt_cx;
    assign skip[1] = y_gt_cy;
    assign skip[2] = y_gt_cx;
    assign skip[3] = x_gt_cy;
    assign skip[4] = OUT_BITS'(r5) >= OUT_BITS'(r_width);
    assign skip[5] = OUT_BITS'(b6) >= OUT_BITS'(r_height);
    assign skip[6] = OUT_BITS'(r7) >= OUT_BITS'(r_width);
    assign skip[7] = OUT_BITS'(b8) >= OUT_BITS'(r_height);

    assign pix_x = '{OUT_BITS'(l1), OUT_BITS'(r5), OUT_BITS'(l1), OUT_BITS'(r5),
                     OUT_BITS'(l3), OUT_BITS'(r7), OUT_BITS'(l3), OUT_BITS'(r7)};
    assign pix_y = '{OUT_BITS'(t2), OUT_BITS'(t2), OUT_BITS'(b6), OUT_BITS'(b6),
                     OUT_BITS'(t4), OUT_BITS'(t4), OUT_BITS'(b8), OUT_BITS'(b8)};

    assign dec_neg = r_dec[DEC_BITS-1];
    assign x16     = DEC_BITS'(x);
    assign y16     = DEC_BITS'(y);
    assign x_next  = r_x + SW'(1);
    assign y_next  = dec_neg ? r_y : r_y - SW'(1);

    always_comb begin
        o_job          = '0;
        o_job.kind     = KIND_NONE;
        o_job.finished = 1'b1;
        if (!idle) begin
            o_job.finished = x_next > y_next;
            if (r_fill) begin
                o_job.kind     = KIND_SPAN;
                o_job.mask     = FILL_MASK;
                o_job.entry[0] = '{px: OUT_BITS'(l1), py: OUT_BITS'(t2), len: OUT_BITS'(len_a)};
                o_job.entry[1] = '{px: OUT_BITS'(l1), py: OUT_BITS'(b6), len: OUT_BITS'(len_a)};
                o_job.entry[2] = '{px: OUT_BITS'(l3), py: OUT_BITS'(b8), len: OUT_BITS'(len_b)};
                o_job.entry[3] = '{px: OUT_BITS'(l3), py: OUT_BITS'(t4), len: OUT_BITS'(len_b)};
            end else begin
                o_job.kind = KIND_PIXEL;
                for (int i = 0; i < LANES; i++) begin
                    o_job.mask[i]      = (skip & SKIP_MASK[i]) == '0;
                    o_job.entry[i].px  = pix_x[i];
                    o_job.entry[i].py  = pix_y[i];
                    o_job.entry[i].len = '0;
                end
            end
        end
    end

    assign o_push = in_acc && is_step;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_x      = r_x;
        n_y      = r_y;
        n_dec    = r_dec;
        n_fill   = r_fill;
        n_active = r_active;
        if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_reg'(i_cfg.addr))
                REG_SCREEN_WIDTH:  n_width  = i_cfg.data;
                REG_SCREEN_HEIGHT: n_height = i_cfg.data;
                default: ;
            endcase
        end
        if (in_acc) begin
            if (!is_step) begin
                n_cx     = i_in.center_x[CW-1:0];
                n_cy     = i_in.center_y[CW-1:0];
                n_fill   = i_in.fill_mode;
                n_x      = '0;
                n_y      = $signed({2'b00, rad});
                n_dec    = DEC_INIT - (DEC_BITS'(rad) << 1);
                n_active = 1'b1;
            end else if (!idle) begin
                n_x   = x_next;
                n_y   = y_next;
                n_dec = dec_neg ? r_dec + (x16 << 2) + DEC_STEP_INC
                                : r_dec + ((x16 - y16) << 2) + DEC_DIAG_INC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_cx     <= '0;
            r_cy     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_dec    <= '0;
            r_fill   <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_x      <= n_x;
            r_y      <= n_y;
            r_dec    <= n_dec;
            r_fill   <= n_fill;
            r_active <= n_active;
        end
    end

endmodule

// File: design/mcr_queue.sv
module mcr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mcr_pkg::t_job     i_job,
    input  logic              i_pop,
    output mcr_pkg::t_job     o_job,
    output mcr_pkg::t_q_stat  o_stat
);
    import mcr_pkg::*;

    localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_job               r_mem [QUEUE_DEPTH];
    logic [PW-1:0]      r_wr, n_wr;
    logic [PW-1:0]      r_rd, n_rd;
    logic [CNTW-1:0]    r_count, n_count;
    logic               do_push, do_pop;

    assign o_stat.full  = (r_count == CNTW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// File: design/mcr_back.sv
module mcr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mcr_pkg::t_job     i_job,
    input  mcr_pkg::t_q_stat  i_q_stat,
    output logic              o_pop,
    mcr_out_if.source         o_out
);
    import mcr_pkg::*;

    logic [LANES-1:0]       r_done, n_done;
    logic                   r_valid, n_valid;
    logic [1:0]             r_kind;
    logic [OUT_BITS-1:0]    r_px, r_py, r_len;
    logic                   r_last, r_fin;

    logic [LANES-1:0]       rem, sel;
    logic                   load, last;
    t_entry                 pick;

    // entries of the head job still to be sent, lowest first
    assign rem  = i_job.mask & ~r_done;
    assign sel  = rem & (~rem + LANES'(1));
    assign last = (rem & ~sel) == '0;
    assign load = !i_q_stat.empty && (!r_valid || o_out.ready);
    assign o_pop = load && last;

    always_comb begin
        pick = '0;
        for (int i = 0; i < LANES; i++) begin
            if (sel[i]) begin
                pick = pick | i_job.entry[i];
            end
        end
    end

    always_comb begin
        n_done  = r_done;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_done  = last ? '0 : (r_done | sel);
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_done  <= n_done;
            r_valid <= n_valid;
        end
    end

    // a job with nothing to draw still sends one empty word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= (rem == '0) ? KIND_NONE : i_job.kind;
            r_px   <= pick.px;
            r_py   <= pick.py;
            r_len  <= pick.len;
            r_last <= last;
            r_fin  <= i_job.finished;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_kind;
    assign o_out.pos_x       = r_px;
    assign o_out.pos_y       = r_py;
    assign o_out.span_length = r_len;
    assign o_out.last        = r_last;
    assign o_out.finished    = r_fin;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mcr_pkg::*;

    logic i_clk;
    logic i_rst_n;

    mcr_in_if  in_if();
    mcr_out_if out_if();
    mcr_cfg_if cfg_if();

    midpoint_circle_rasterizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    typedef struct {
        t_kind               kind;
        logic [OUT_BITS-1:0] pos_x;
        logic [OUT_BITS-1:0] pos_y;
        logic [OUT_BITS-1:0] span_length;
        logic                last;
        logic                finished;
    } t_draw;

    t_draw pending_draws [$];

    // mirrored block state
    logic [CFG_BITS-1:0] scr_w = WIDTH_RESET;
    logic [CFG_BITS-1:0] scr_h = HEIGHT_RESET;
    logic [IN_BITS-1:0]  ctr_col = '0;
    logic [IN_BITS-1:0]  ctr_row = '0;
    int                  cur_x = 0;
    int                  cur_y = 0;
    shortint             dec_var = 0;
    bit                  fill_on = 1'b0;
    bit                  circle_loaded = 1'b0;

    int fail_count    = 0;
    int send_idle_pct = 34;
    int recv_idle_pct = 63;
    int hold_req      = 0;
    int hold_left     = 0;

    always #6 i_clk = ~i_clk;

    initial begin
        #5000000;
        $display("** midpoint_circle_rasterizer: FAILED **");
        $finish;
    end

    function automatic t_draw make_draw(input t_kind k, input int px, input int py,
                                        input int len);
        t_draw d;
        d.kind        = k;
        d.pos_x       = px[OUT_BITS-1:0];
        d.pos_y       = py[OUT_BITS-1:0];
        d.span_length = len[OUT_BITS-1:0];
        d.last        = 1'b0;
        d.finished    = 1'b0;
        return d;
    endfunction

    function automatic void rasterize_request(input t_req req,
                                              input logic [IN_BITS-1:0] col_in,
                                              input logic [IN_BITS-1:0] row_in,
                                              input logic [IN_BITS-1:0] rad_in,
                                              input logic fill_in);
        int cx, cy, x, y;
        int l1, t2, l3, t4, r5, b6, r7, b8;
        int ox [LANES];
        int oy [LANES];
        logic [LANES-1:0] skip;
        t_draw batch [$];
        bit done;
        if (req == REQ_START) begin
            ctr_col       = col_in;
            ctr_row       = row_in;
            fill_on       = fill_in;
            cur_x         = 0;
            cur_y         = int'(rad_in);
            dec_var       = shortint'(int'(DEC_INIT) - 2 * int'(rad_in));
            circle_loaded = 1'b1;
            return;
        end
        if (!circle_loaded || cur_x > cur_y) begin
            batch.push_back(make_draw(KIND_NONE, 0, 0, 0));
            done = 1'b1;
        end else begin
            cx = int'(ctr_col);
            cy = int'(ctr_row);
            x  = cur_x;
            y  = cur_y;
            // left and top edges clamp at zero
            l1 = (x > cx) ? 0 : cx - x;
            t2 = (y > cy) ? 0 : cy - y;
            l3 = (y > cx) ? 0 : cx - y;
            t4 = (x > cy) ? 0 : cy - x;
            r5 = cx + x;
            b6 = cy + y;
            r7 = cx + y;
            b8 = cy + x;
            if (fill_on) begin
                batch.push_back(make_draw(KIND_SPAN, l1, t2, r5 - l1));
                batch.push_back(make_draw(KIND_SPAN, l1, b6, r5 - l1));
                batch.push_back(make_draw(KIND_SPAN, l3, b8, r7 - l3));
                batch.push_back(make_draw(KIND_SPAN, l3, t4, r7 - l3));
            end else begin
                skip = {b8 >= int'(scr_h), r7 >= int'(scr_w), b6 >= int'(scr_h),
                        r5 >= int'(scr_w), x > cy, y > cx, y > cy, x > cx};
                ox = '{l1, r5, l1, r5, l3, r7, l3, r7};
                oy = '{t2, t2, b6, b6, t4, t4, b8, b8};
                for (int i = 0; i < LANES; i++) begin
                    if ((skip & SKIP_MASK[i]) == '0) begin
                        batch.push_back(make_draw(KIND_PIXEL, ox[i], oy[i], 0));
                    end
                end
                if (batch.size() == 0) begin
                    batch.push_back(make_draw(KIND_NONE, 0, 0, 0));
                end
            end
            if (dec_var < 0) begin
                dec_var = shortint'(int'(dec_var) + 4 * x + int'(DEC_STEP_INC));
            end else begin
                dec_var = shortint'(int'(dec_var) + 4 * (x - y) + int'(DEC_DIAG_INC));
                cur_y   = y - 1;
            end
            cur_x = x + 1;
            done  = cur_x > cur_y;
        end
        foreach (batch[i]) begin
            batch[i].finished = done;
            batch[i].last     = (i == batch.size() - 1);
            pending_draws.push_back(batch[i]);
        end
    endfunction

    // called right after a rising edge; returns right after the edge that took the word
    task automatic send_req(input t_req req, input logic [IN_BITS-1:0] col,
                            input logic [IN_BITS-1:0] row, input logic [IN_BITS-1:0] rad,
                            input logic fill);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.req_type  <= req;
        in_if.center_x  <= col;
        in_if.center_y  <= row;
        in_if.radius    <= rad;
        in_if.fill_mode <= fill;
        do @(negedge i_clk); while (in_if.ready !== 1'b1);
        rasterize_request(req, col, row, rad, fill);
        @(posedge i_clk);
    endtask

    task automatic send_step();
        send_req(REQ_STEP, IN_BITS'($urandom_range(2047)), IN_BITS'($urandom_range(2047)),
                 IN_BITS'($urandom_range(2047)), 1'($urandom_range(1)));
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_BITS-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= idx;
        cfg_if.data  <= val;
        do @(negedge i_clk); while (cfg_if.ready !== 1'b1);
        if (idx == REG_SCREEN_WIDTH) begin
            scr_w = val;
        end else begin
            scr_h = val;
        end
        @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_screen(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
        wait_idle();
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
    endtask

    task automatic test_directed_edges();
        // step with no circle loaded
        send_step();
        // zero radius, then a step past the end
        send_req(REQ_START, 11'd5, 11'd5, 11'd0, 1'b0);
        send_step();
        send_step();
        // fill clamped at the left and top edges
        send_req(REQ_START, 11'd0, 11'd0, 11'd3, 1'b1);
        repeat (4) send_step();
        send_req(REQ_START, 11'd2047, 11'd2047, 11'd2047, 1'b1);
        send_step();
        send_req(REQ_START, 11'd2047, 11'd2047, 11'd2047, 1'b0);
        send_step();
        // right and bottom edges of the reset screen
        send_req(REQ_START, 11'd239, 11'd319, 11'd1, 1'b0);
        send_step();
        send_step();
        send_req(REQ_START, 11'd0, 11'd0, 11'd2047, 1'b0);
        send_step();
    endtask

    task automatic test_tiny_screens();
        // every octant pixel clipped
        set_screen(11'd1, 11'd1);
        send_req(REQ_START, 11'd0, 11'd0, 11'd5, 1'b0);
        send_step();
        set_screen(11'd0, 11'd0);
        send_req(REQ_START, 11'd10, 11'd10, 11'd4, 1'b0);
        send_step();
        send_step();
        set_screen(11'd2047, 11'd2047);
        send_req(REQ_START, 11'd2040, 11'd2040, 11'd10, 1'b0);
        send_step();
    endtask

    task automatic test_output_stall();
        set_screen(11'd2047, 11'd2047);
        send_idle_pct = 0;
        hold_req      = 300;
        send_req(REQ_START, 11'd500, 11'd500, 11'd30, 1'b0);
        repeat (14) send_step();
        wait_idle();
    endtask

    task automatic draw_random_circles(input int n_items);
        int sent;
        int cap;
        int nsteps;
        logic [IN_BITS-1:0] col, row, rad;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                col = IN_BITS'(($urandom_range(3) == 0) ? $urandom_range(31)
                                                         : $urandom_range(2047));
                row = IN_BITS'(($urandom_range(3) == 0) ? $urandom_range(31)
                                                         : $urandom_range(2047));
                rad = IN_BITS'(($urandom_range(9) == 0) ? $urandom_range(2047)
                                                         : $urandom_range(24));
                send_req(REQ_START, col, row, rad, 1'($urandom_range(1)));
                sent++;
                // some circles are abandoned early
                cap    = ($urandom_range(99) < 15) ? $urandom_range(3) : 40;
                nsteps = 0;
                while (nsteps < cap && cur_x <= cur_y) begin
                    send_step();
                    nsteps++;
                    sent++;
                end
                if ($urandom_range(3) == 0) begin
                    send_step();
                    sent++;
                end
            end else begin
                send_req(t_req'($urandom_range(1)), IN_BITS'($urandom_range(2047)),
                         IN_BITS'($urandom_range(2047)), IN_BITS'($urandom_range(2047)),
                         1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    task automatic test_random_circles();
        set_screen(CFG_BITS'($urandom_range(1, 2047)), CFG_BITS'($urandom_range(1, 2047)));
        send_idle_pct = 34;
        recv_idle_pct = 63;
        draw_random_circles(70);
        set_screen(CFG_BITS'($urandom_range(1, 300)), CFG_BITS'($urandom_range(1, 300)));
        send_idle_pct = 63;
        recv_idle_pct = 34;
        draw_random_circles(70);
        set_screen(CFG_BITS'($urandom_range(2047)), CFG_BITS'($urandom_range(2047)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        draw_random_circles(70);
    endtask

    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void check_field(input string name, input logic [OUT_BITS-1:0] want,
                                        input logic [OUT_BITS-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // sampled mid-cycle so the word seen is the one taken at the next rising edge
    always @(negedge i_clk) begin : draw_check
        t_draw want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_draws.size() == 0) begin
                $error("unexpected word: kind %0d pos %0d,%0d", out_if.kind, out_if.pos_x,
                       out_if.pos_y);
                fail_count++;
            end else begin
                want = pending_draws.pop_front();
                check_field("kind", OUT_BITS'(want.kind), OUT_BITS'(out_if.kind));
                check_field("pos_x", want.pos_x, out_if.pos_x);
                check_field("pos_y", want.pos_y, out_if.pos_y);
                check_field("span_length", want.span_length, out_if.span_length);
                check_field("last", OUT_BITS'(want.last), OUT_BITS'(out_if.last));
                check_field("finished", OUT_BITS'(want.finished),
                            OUT_BITS'(out_if.finished));
            end
        end
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.req_type  = REQ_START;
        in_if.center_x  = '0;
        in_if.center_y  = '0;
        in_if.radius    = '0;
        in_if.fill_mode = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.addr     = REG_SCREEN_WIDTH;
        cfg_if.data     = '0;
        out_if.ready    = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_tiny_screens();
        test_output_stall();
        test_random_circles();
        wait_idle();

        if (fail_count == 0) begin
            $display("** midpoint_circle_rasterizer: PASSED **");
        end else begin
            $display("** midpoint_circle_rasterizer: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
design/mcr_pkg.sv
design/mcr_if.sv
design/mcr_front.sv
design/mcr_queue.sv
design/mcr_back.sv
design/midpoint_circle_rasterizer.sv
dv/testbench.sv
